/* rtl/cll_pkg.sv */
// Shared constants, codes and types of the cursor linked list engine.
package cll_pkg;

    localparam int CAPACITY  = 256;
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int DATA_BITS = 32;

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [DATA_BITS-1:0] t_data;

    typedef enum logic [3:0] {
        CMD_RESET_CURSOR = 4'd0,
        CMD_READ         = 4'd1,
        CMD_FORWARD      = 4'd2,
        CMD_BACKWARD     = 4'd3,
        CMD_INS_BEFORE   = 4'd4,
        CMD_INS_AFTER    = 4'd5,
        CMD_DELETE       = 4'd6,
        CMD_FIND         = 4'd7,
        CMD_CLEAR        = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_FULL      = 3'd2,
        STS_NULL      = 3'd3,
        STS_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_LINK,
        ST_LINK2,
        ST_FRD,
        ST_FCMP,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic  en;
        t_slot addr;
        t_slot data;
    } t_link_wr;

    typedef struct packed {
        logic  en;
        t_slot addr;
        t_data data;
    } t_data_wr;

    typedef struct packed {
        logic  pop;
        logic  push;
        logic  clear;
        t_slot slot;
    } t_free_op;

endpackage

/* rtl/cll_links.sv */
// Next, prior and data stores of the list entries, with registered reads.
module cll_links (
    input  logic              i_clk,
    input  cll_pkg::t_slot    i_rd_addr,
    input  cll_pkg::t_link_wr i_next_wr,
    input  cll_pkg::t_link_wr i_prior_wr,
    input  cll_pkg::t_data_wr i_data_wr,
    output cll_pkg::t_slot    o_next,
    output cll_pkg::t_slot    o_prior,
    output cll_pkg::t_data    o_data
);
    import cll_pkg::*;

    t_slot r_next_mem  [CAPACITY];
    t_slot r_prior_mem [CAPACITY];
    t_data r_data_mem  [CAPACITY];
    t_slot r_next_q;
    t_slot r_prior_q;
    t_data r_data_q;

    always_ff @(posedge i_clk) begin
        if (i_next_wr.en) begin
            r_next_mem[i_next_wr.addr] <= i_next_wr.data;
        end
        if (i_prior_wr.en) begin
            r_prior_mem[i_prior_wr.addr] <= i_prior_wr.data;
        end
        if (i_data_wr.en) begin
            r_data_mem[i_data_wr.addr] <= i_data_wr.data;
        end
        r_next_q  <= r_next_mem[i_rd_addr];
        r_prior_q <= r_prior_mem[i_rd_addr];
        r_data_q  <= r_data_mem[i_rd_addr];
    end

    assign o_next  = r_next_q;
    assign o_prior = r_prior_q;
    assign o_data  = r_data_q;

endmodule

/* rtl/cll_free.sv */
// Free slot stack with a watermark that stands in for its reset contents.
module cll_free (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cll_pkg::t_free_op i_op,
    output cll_pkg::t_slot    o_slot,
    output cll_pkg::t_cnt     o_count
);
    import cll_pkg::*;

    t_slot r_mem [CAPACITY];
    t_cnt  r_count;
    t_cnt  r_mark;
    t_slot r_mem_q;
    t_slot r_fresh_val;
    logic  r_fresh;
    t_cnt  w_top;

    // Entries below the watermark have not been written since the last clear.
    assign w_top = r_count - t_cnt'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= t_cnt'(CAPACITY);
            r_mark  <= t_cnt'(CAPACITY);
        end else if (i_op.clear) begin
            r_count <= t_cnt'(CAPACITY);
            r_mark  <= t_cnt'(CAPACITY);
        end else if (i_op.pop) begin
            r_count <= w_top;
        end else if (i_op.push && r_count < t_cnt'(CAPACITY)) begin
            r_count <= r_count + t_cnt'(1);
            if (r_count < r_mark) begin
                r_mark <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push && r_count < t_cnt'(CAPACITY)) begin
            r_mem[r_count[SLOT_BITS-1:0]] <= i_op.slot;
        end
        r_mem_q     <= r_mem[w_top[SLOT_BITS-1:0]];
        r_fresh     <= w_top < r_mark;
        r_fresh_val <= t_slot'(CAPACITY - 1) - w_top[SLOT_BITS-1:0];
    end

    assign o_slot  = r_fresh ? r_fresh_val : r_mem_q;
    assign o_count = r_count;

endmodule

/* rtl/cursor_linked_list_engine.sv */
// Top level of the cursor linked list engine: sequencer and result register.
//
// A circular doubly linked list of non-zero handles with one cursor. Commands
// arrive on the input channel (i_in_valid / o_in_ready) as a command code and a
// handle; each item yields exactly one result on the output channel
// (o_out_valid / i_out_ready) carrying a status, a handle, the list length and
// an empty flag. The block works on one item at a time under a small
// sequencer; the link stores have registered reads, so each access waits on
// its read register. Reset cursor, clear and rejected commands go from execute
// straight to the result; read, step and delete pass a read-wait state; inserts
// pass two link states (one into an empty list). Find walks the list from the
// head, reading and then comparing each entry visited until a match or the end.
// The input is ready again in the cycle after the result is loaded, even if
// the receiver has not yet taken it; a held result stalls the next command
// only when that command finishes and finds the result register still full.
// Synchronous reset empties the list, restores every slot to the free stack
// (a watermark marks untouched entries) and drops any result.
module cursor_linked_list_engine (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [3:0]               i_command,
    input  logic [31:0]              i_data_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [2:0]               o_status,
    output logic [31:0]              o_data_out,
    output logic [8:0]               o_length,
    output logic                     o_is_empty
);
    import cll_pkg::*;

    t_state  r_state, n_state;
    t_cmd    r_cmd;
    t_data   r_din;
    t_slot   r_head, n_head;
    t_slot   r_cursor, n_cursor;
    t_cnt    r_count, n_count;
    t_status r_status, n_status;
    t_data   r_dout, n_dout;
    t_slot   r_slot, n_slot;
    t_slot   r_nb, n_nb;
    t_slot   r_walk, n_walk;
    t_cnt    r_idx, n_idx;

    logic    r_ov;
    t_status r_o_status;
    t_data   r_o_data;
    t_cnt    r_o_len;

    t_slot    w_rd_addr;
    t_link_wr w_next_wr, w_prior_wr;
    t_data_wr w_data_wr;
    t_slot    w_next_q, w_prior_q;
    t_data    w_data_q;
    t_free_op w_free_op;
    t_slot    w_free_slot;
    t_cnt     w_free_count;
    logic     w_accept, w_load, w_match, w_last;

    cll_links u_links (
        .i_clk      (i_clk),
        .i_rd_addr  (w_rd_addr),
        .i_next_wr  (w_next_wr),
        .i_prior_wr (w_prior_wr),
        .i_data_wr  (w_data_wr),
        .o_next     (w_next_q),
        .o_prior    (w_prior_q),
        .o_data     (w_data_q)
    );

    cll_free u_free (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_free_op),
        .o_slot  (w_free_slot),
        .o_count (w_free_count)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_state == ST_RESP) && (!r_ov || i_out_ready);
    // The single compare unit of the search walk.
    assign w_match    = (w_data_q == r_din);
    assign w_last     = (r_idx + t_cnt'(1)) == r_count;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_RESP;
                case (r_cmd)
                    CMD_READ, CMD_FORWARD, CMD_BACKWARD, CMD_DELETE: begin
                        if (r_count != '0) n_state = ST_RDWAIT;
                    end
                    CMD_INS_BEFORE, CMD_INS_AFTER: begin
                        if (r_din != '0 && w_free_count != '0) n_state = ST_LINK;
                    end
                    CMD_FIND: begin
                        if (r_din != '0 && r_count != '0) n_state = ST_FRD;
                    end
                    default: n_state = ST_RESP;
                endcase
            end
            ST_RDWAIT: n_state = ST_RESP;
            ST_LINK:   n_state = (r_count == '0) ? ST_RESP : ST_LINK2;
            ST_LINK2:  n_state = ST_RESP;
            ST_FRD:    n_state = ST_FCMP;
            ST_FCMP:   n_state = (w_match || w_last) ? ST_RESP : ST_FRD;
            ST_RESP: begin
                if (w_load) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath and store controls.
    always_comb begin
        n_head     = r_head;
        n_cursor   = r_cursor;
        n_count    = r_count;
        n_status   = r_status;
        n_dout     = r_dout;
        n_slot     = r_slot;
        n_nb       = r_nb;
        n_walk     = r_walk;
        n_idx      = r_idx;
        w_rd_addr  = r_cursor;
        w_next_wr  = '0;
        w_prior_wr = '0;
        w_data_wr  = '0;
        w_free_op  = '0;
        case (r_state)
            ST_EXEC: begin
                n_status = STS_OK;
                n_dout   = '0;
                case (r_cmd)
                    CMD_RESET_CURSOR: begin
                        if (r_count != '0) n_cursor = r_head;
                    end
                    CMD_READ, CMD_FORWARD, CMD_BACKWARD, CMD_DELETE: begin
                        if (r_count == '0) n_status = STS_EMPTY;
                    end
                    CMD_INS_BEFORE, CMD_INS_AFTER: begin
                        // A null handle is reported ahead of a full store.
                        if (r_din == '0) begin
                            n_status = STS_NULL;
                        end else if (w_free_count == '0) begin
                            n_status = STS_FULL;
                        end else begin
                            w_free_op.pop = 1'b1;
                        end
                    end
                    CMD_FIND: begin
                        n_walk = r_head;
                        n_idx  = '0;
                        if (r_din == '0) begin
                            n_status = STS_NULL;
                        end else if (r_count == '0) begin
                            n_status = STS_NOT_FOUND;
                        end
                    end
                    CMD_CLEAR: begin
                        w_free_op.clear = 1'b1;
                        n_head   = '0;
                        n_cursor = '0;
                        n_count  = '0;
                    end
                    default: n_status = STS_OK;
                endcase
            end
            ST_RDWAIT: begin
                n_dout = w_data_q;
                case (r_cmd)
                    CMD_FORWARD:  n_cursor = w_next_q;
                    CMD_BACKWARD: n_cursor = w_prior_q;
                    CMD_DELETE: begin
                        if (r_count == t_cnt'(1)) begin
                            n_head   = '0;
                            n_cursor = '0;
                        end else begin
                            w_next_wr  = '{en: 1'b1, addr: w_prior_q, data: w_next_q};
                            w_prior_wr = '{en: 1'b1, addr: w_next_q, data: w_prior_q};
                            n_cursor   = w_next_q;
                            if (r_head == r_cursor) n_head = w_next_q;
                        end
                        n_count        = r_count - t_cnt'(1);
                        w_free_op.push = 1'b1;
                        w_free_op.slot = r_cursor;
                    end
                    default: n_dout = w_data_q;
                endcase
            end
            ST_LINK: begin
                n_slot    = w_free_slot;
                w_data_wr = '{en: 1'b1, addr: w_free_slot, data: r_din};
                if (r_count == '0) begin
                    w_next_wr  = '{en: 1'b1, addr: w_free_slot, data: w_free_slot};
                    w_prior_wr = '{en: 1'b1, addr: w_free_slot, data: w_free_slot};
                    n_head     = w_free_slot;
                    n_cursor   = w_free_slot;
                    n_count    = r_count + t_cnt'(1);
                end else if (r_cmd == CMD_INS_BEFORE) begin
                    w_next_wr  = '{en: 1'b1, addr: w_free_slot, data: r_cursor};
                    w_prior_wr = '{en: 1'b1, addr: w_free_slot, data: w_prior_q};
                    n_nb       = w_prior_q;
                end else begin
                    w_next_wr  = '{en: 1'b1, addr: w_free_slot, data: w_next_q};
                    w_prior_wr = '{en: 1'b1, addr: w_free_slot, data: r_cursor};
                    n_nb       = w_next_q;
                end
            end
            ST_LINK2: begin
                if (r_cmd == CMD_INS_BEFORE) begin
                    w_next_wr  = '{en: 1'b1, addr: r_nb, data: r_slot};
                    w_prior_wr = '{en: 1'b1, addr: r_cursor, data: r_slot};
                    if (r_head == r_cursor) n_head = r_slot;
                end else begin
                    w_next_wr  = '{en: 1'b1, addr: r_cursor, data: r_slot};
                    w_prior_wr = '{en: 1'b1, addr: r_nb, data: r_slot};
                end
                n_cursor = r_slot;
                n_count  = r_count + t_cnt'(1);
            end
            ST_FRD: begin
                w_rd_addr = r_walk;
            end
            ST_FCMP: begin
                if (w_match) begin
                    n_cursor = r_walk;
                end else if (w_last) begin
                    n_status = STS_NOT_FOUND;
                end else begin
                    n_idx  = r_idx + t_cnt'(1);
                    n_walk = w_next_q;
                end
            end
            default: w_rd_addr = r_cursor;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_cursor <= '0;
            r_count  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_cursor <= n_cursor;
            r_count  <= n_count;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_command);
            r_din <= i_data_in;
        end
        r_status <= n_status;
        r_dout   <= n_dout;
        r_slot   <= n_slot;
        r_nb     <= n_nb;
        r_walk   <= n_walk;
        r_idx    <= n_idx;
        if (w_load) begin
            r_o_status <= r_status;
            r_o_data   <= r_dout;
            r_o_len    <= r_count;
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_o_status;
    assign o_data_out  = r_o_data;
    assign o_length    = r_o_len;
    assign o_is_empty  = (r_o_len == '0);

    // Entries in the list and slots on the free stack add up to the store size whenever the sequencer is idle.
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> (r_count + w_free_count) == t_cnt'(CAPACITY))
        else $error("list and free stack disagree on slot count");

    // An accepted item starts the sequencer at once.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_EXEC)
        else $error("accepted item did not start");

    // Every error result carries a zero handle.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STS_OK |-> o_data_out == '0)
        else $error("error result carries data");

    // The length never exceeds the store size.
    a_length_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_length <= t_cnt'(CAPACITY))
        else $error("length beyond capacity");

endmodule
